// ----- rtl/mst_pkg.sv -----
// Shared constants, command codes and status codes for the min-tracking stack.
package mst_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  // Stored words carry two extra bits so that 2*value-min always fits.
  localparam int WORD_WIDTH = DATA_WIDTH + 2;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

endpackage

// ----- rtl/mst_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
module mst_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/min_tracking_stack.sv -----
// Min-tracking stack: push, pop and query of a bounded LIFO that reports its minimum.
// Push and read commands give their result in the cycle after the transfer, at one per cycle
// while busy is low. A pop that succeeds passes through S_POP: the entry below the top is
// fetched from the registered RAM read port to refresh the cached top word, with busy high.
// Results are single-cycle strobes on done; the receiver cannot stall.
// Synchronous reset empties the stack and clears the minimum; RAM contents are not cleared.
module min_tracking_stack
  import mst_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [DATA_WIDTH-1:0] removed_value,
  output logic signed [DATA_WIDTH-1:0] top_value,
  output logic signed [DATA_WIDTH-1:0] min_value,
  output logic                         is_empty
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t                         state;
  logic [CNT_W-1:0]               count;
  logic signed [DATA_WIDTH-1:0]   cur_min;
  logic signed [WORD_WIDTH-1:0]   top_word;
  logic signed [DATA_WIDTH-1:0]   pend_removed;

  logic                           accept;
  logic                           empty;
  logic                           full;
  logic signed [WORD_WIDTH-1:0]   x_ext;
  logic signed [WORD_WIDTH-1:0]   min_ext;
  logic signed [WORD_WIDTH-1:0]   enc_word;
  logic signed [WORD_WIDTH-1:0]   rec_word;
  logic signed [WORD_WIDTH-1:0]   rd_word;
  logic signed [DATA_WIDTH-1:0]   top_dec;
  logic signed [DATA_WIDTH-1:0]   rd_dec;
  logic                           below_min;
  logic                           top_plain;

  logic                           ram_we;
  logic [ADDR_W-1:0]              ram_waddr;
  logic [WORD_WIDTH-1:0]          ram_wdata;
  logic                           ram_re;
  logic [ADDR_W-1:0]              ram_raddr;
  logic [WORD_WIDTH-1:0]          ram_rdata;

  assign busy   = (state == S_POP);
  assign accept = start && !busy;
  assign empty  = (count == '0);
  assign full   = (count == CNT_W'(DEPTH));

  assign x_ext     = WORD_WIDTH'(push_value);
  assign min_ext   = WORD_WIDTH'(cur_min);
  assign enc_word  = (x_ext + x_ext) - min_ext;
  assign rec_word  = (min_ext + min_ext) - top_word;
  assign below_min = (push_value < cur_min);
  assign top_plain = (top_word >= min_ext);
  assign top_dec   = top_plain ? top_word[DATA_WIDTH-1:0] : cur_min;

  assign rd_word = $signed(ram_rdata);
  assign rd_dec  = (rd_word >= min_ext) ? rd_word[DATA_WIDTH-1:0] : cur_min;

  // A push writes the slot above the top; a pop fetches the slot below the top.
  assign ram_we    = accept && (cmd == CMD_PUSH) && !full;
  assign ram_waddr = count[ADDR_W-1:0];
  assign ram_wdata = (empty || !below_min) ? x_ext : enc_word;
  assign ram_re    = accept && (cmd == CMD_POP) && (count > CNT_W'(1));
  assign ram_raddr = ADDR_W'(count - CNT_W'(2));

  mst_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cur_min <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            // Default result is a plain read of the current state.
            status        <= ST_OK;
            removed_value <= '0;
            top_value     <= empty ? '0 : top_dec;
            min_value     <= empty ? '0 : cur_min;
            is_empty      <= empty;
            case (cmd)
              CMD_PUSH: begin
                if (full) begin
                  status <= ST_OVERFLOW;
                  done   <= 1'b1;
                end else begin
                  count     <= count + CNT_W'(1);
                  top_word  <= ram_wdata;
                  top_value <= push_value;
                  is_empty  <= 1'b0;
                  if (empty || below_min) begin
                    cur_min   <= push_value;
                    min_value <= push_value;
                  end else begin
                    min_value <= cur_min;
                  end
                  done <= 1'b1;
                end
              end
              CMD_POP: begin
                if (empty) begin
                  status <= ST_UNDERFLOW;
                  done   <= 1'b1;
                end else begin
                  // A stored word below the minimum marks the minimum itself.
                  count        <= count - CNT_W'(1);
                  pend_removed <= top_dec;
                  if (!top_plain) begin
                    cur_min <= rec_word[DATA_WIDTH-1:0];
                  end
                  state <= S_POP;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_POP: begin
          status        <= ST_OK;
          removed_value <= pend_removed;
          top_word      <= rd_word;
          top_value     <= empty ? '0 : rd_dec;
          min_value     <= empty ? '0 : cur_min;
          is_empty      <= empty;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
